[rtl/core/cda_pkg.sv]
// Shared widths, constants, control types and the month length table for the date advancer.
`default_nettype none

package cda_pkg;

    // Field widths
    localparam int YEAR_W     = 14;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int DAYNUM_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // Register indexes on the config channel
    localparam logic [CFG_IDX_W-1:0] REG_START_YEAR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_MONTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_DAY   = 2'd2;

    // Reset values of the start date
    localparam logic [YEAR_W-1:0]  RST_START_YEAR  = 14'd1777;
    localparam logic [MONTH_W-1:0] RST_START_MONTH = 4'd4;
    localparam logic [DAY_W-1:0]   RST_START_DAY   = 5'd30;

    // Calendar constants
    localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W:0]   MONTHS_YEAR = 5'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
    localparam logic [DAY_W-1:0]   FEB_DAYS    = 5'd28;
    localparam logic [DAY_W-1:0]   FEB_LEAP    = 5'd29;

    // Year split into century and year-of-century: q = (y * 5243) >> 19 is y / 100
    // for every 14-bit year.
    localparam int QUO_W     = 8;
    localparam int REM_W     = 7;
    localparam int DIV_MUL_W = 13;
    localparam int PROD_W    = YEAR_W + DIV_MUL_W;
    localparam int DIV_SHIFT = 19;
    localparam logic [DIV_MUL_W-1:0] DIV100_MUL = 13'd5243;
    localparam logic [6:0]           HUNDRED    = 7'd100;
    localparam logic [REM_W-1:0]     REM_LAST   = 7'd99;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_REM  = 5'b00100,
        ST_RUN  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;   // take start date and count
        logic div;    // year / 100
        logic rem;    // year % 100 and century phase
        logic step;   // advance one day
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic more;   // another day to advance
    } t_dp_status;

    // Days in month; months outside 1..12 have no days
    function automatic logic [DAY_W-1:0] month_length(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        case (month)
            4'd1:    len = 5'd31;
            4'd2:    len = leap ? FEB_LEAP : FEB_DAYS;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[rtl/core/cda_if.sv]
// Channel interfaces: day input, date result and config write.
`default_nettype none

interface cda_in_if import cda_pkg::*;;
    logic                valid;
    logic                ready;
    logic [DAYNUM_W-1:0] day_number;
    modport source (output valid, output day_number, input ready);
    modport sink   (input valid, input day_number, output ready);
endinterface

interface cda_out_if import cda_pkg::*;;
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  out_year;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;
    modport source (output valid, output out_year, output out_month, output out_day,
                    input ready);
    modport sink   (input valid, input out_year, input out_month, input out_day,
                    output ready);
endinterface

interface cda_cfg_if import cda_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/cda_ctrl.sv]
// Controller state machine: sequences load, year split, day stepping and result hand-off.
`default_nettype none

module cda_ctrl import cda_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    input  wire logic       i_out_free,
    output logic            o_out_load
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = ST_REM;
            end
            ST_REM: begin
                o_cmd.rem = 1'b1;
                n_state   = ST_RUN;
            end
            ST_RUN: begin
                if (i_status.more) begin
                    o_cmd.step = 1'b1;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/cda_dpath.sv]
// Datapath: date registers, day counter and incremental leap-year tracking.
`default_nettype none

module cda_dpath import cda_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire t_dp_cmd             i_cmd,
    input  wire logic [DAYNUM_W-1:0] i_day_number,
    input  wire logic [YEAR_W-1:0]   i_start_year,
    input  wire logic [MONTH_W-1:0]  i_start_month,
    input  wire logic [DAY_W-1:0]    i_start_day,
    output t_dp_status               o_status,
    output logic [YEAR_W-1:0]        o_year,
    output logic [MONTH_W-1:0]       o_month,
    output logic [DAY_W-1:0]         o_day
);

    localparam int LOAD_BITS = (COUNT_BITS < DAYNUM_W) ? COUNT_BITS : DAYNUM_W;

    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [YEAR_W-1:0]     r_year, n_year;
    logic [MONTH_W-1:0]    r_month, n_month;
    logic [DAY_W-1:0]      r_day, n_day;
    logic [QUO_W-1:0]      r_quo, n_quo;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic [1:0]            r_cent, n_cent;

    logic [COUNT_BITS-1:0] w_count;
    logic [PROD_W-1:0]     w_prod;
    logic [YEAR_W-1:0]     w_hund;
    logic                  w_leap;
    logic [DAY_W:0]        w_day_inc;
    logic [MONTH_W:0]      w_month_inc;
    logic [DAY_W-1:0]      w_len;

    always_comb begin
        w_count                = '0;
        w_count[LOAD_BITS-1:0] = i_day_number[LOAD_BITS-1:0];
    end

    assign w_prod = PROD_W'(r_year) * PROD_W'(DIV100_MUL);
    assign w_hund = YEAR_W'(r_quo) * YEAR_W'(HUNDRED);

    // leap: century years go by the century phase, others by the low year bits
    assign w_leap = (r_rem == '0) ? (r_cent == 2'd0) : (r_year[1:0] == 2'd0);
    assign w_len  = month_length(r_month, w_leap);

    always_comb begin
        n_cnt   = r_cnt;
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cent  = r_cent;
        w_day_inc   = {1'b0, r_day} + 1'b1;
        w_month_inc = {1'b0, r_month};
        if (i_cmd.load) begin
            n_cnt   = w_count;
            n_year  = i_start_year;
            n_month = i_start_month;
            n_day   = i_start_day;
        end
        if (i_cmd.div) begin
            n_quo = w_prod[PROD_W-1 -: QUO_W];
        end
        if (i_cmd.rem) begin
            n_rem  = REM_W'(r_year - w_hund);
            n_cent = r_quo[1:0];
        end
        if (i_cmd.step) begin
            n_cnt = r_cnt - 1'b1;
            if (w_day_inc > {1'b0, w_len}) begin
                n_day       = DAY_FIRST;
                w_month_inc = {1'b0, r_month} + 1'b1;
            end else begin
                n_day = w_day_inc[DAY_W-1:0];
            end
            n_month = w_month_inc[MONTH_W-1:0];
            if (w_month_inc > MONTHS_YEAR) begin
                n_month = MONTH_JAN;
                n_year  = r_year + 1'b1;
                if (r_year == '1) begin
                    // wrap to year zero
                    n_rem  = '0;
                    n_cent = 2'd0;
                end else if (r_rem == REM_LAST) begin
                    n_rem  = '0;
                    n_cent = r_cent + 1'b1;
                end else begin
                    n_rem = r_rem + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_year  <= n_year;
        r_month <= n_month;
        r_day   <= n_day;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_cent  <= n_cent;
    end

    assign o_status.more = (r_cnt > COUNT_BITS'(1));
    assign o_year        = r_year;
    assign o_month       = r_month;
    assign o_day         = r_day;

endmodule

`default_nettype wire

[rtl/core/calendar_date_advance.sv]
// Top level: config registers, controller, datapath and the result register.
//
//  channel | dir | beat contents                | accepted when
//  i_in    | in  | day_number[15:0]             | valid & ready
//  o_res   | out | out_year, out_month, out_day | valid & ready
//  i_cfg   | in  | index[1:0], data[13:0]       | valid & ready (ready always high)
//
// Sequence: an item is loaded on accept, the start year is split by 100 (quotient, then
// remainder and century phase), then the day-advance loop steps max(n - 1, 0) days,
// n = day_number mod 2^COUNT_BITS, one day per cycle, and exits to the result hand-off.
// Reset: synchronous, active low; start date returns to 1777-04-30, channels idle.
// Stalls: the result register holds one finished date; the next item is taken
// while it waits, and the controller holds its own finished date until it drains.
`default_nettype none

module calendar_date_advance import cda_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cda_in_if.sink     i_in,
    cda_out_if.source  o_res,
    cda_cfg_if.sink    i_cfg
);

    // Start date registers
    logic [YEAR_W-1:0]  r_start_year;
    logic [MONTH_W-1:0] r_start_month;
    logic [DAY_W-1:0]   r_start_day;

    // Result register
    logic               r_out_valid;
    logic [YEAR_W-1:0]  r_out_year;
    logic [MONTH_W-1:0] r_out_month;
    logic [DAY_W-1:0]   r_out_day;

    t_dp_cmd            w_cmd;
    t_dp_status         w_status;
    logic               w_out_free;
    logic               w_out_load;
    logic [YEAR_W-1:0]  w_year;
    logic [MONTH_W-1:0] w_month;
    logic [DAY_W-1:0]   w_day;

    // Config writes: every beat is taken; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_year  <= RST_START_YEAR;
            r_start_month <= RST_START_MONTH;
            r_start_day   <= RST_START_DAY;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_START_YEAR:  r_start_year  <= i_cfg.data[YEAR_W-1:0];
                REG_START_MONTH: r_start_month <= i_cfg.data[MONTH_W-1:0];
                REG_START_DAY:   r_start_day   <= i_cfg.data[DAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .i_out_free (w_out_free),
        .o_out_load (w_out_load)
    );

    cda_dpath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .i_day_number  (i_in.day_number),
        .i_start_year  (r_start_year),
        .i_start_month (r_start_month),
        .i_start_day   (r_start_day),
        .o_status      (w_status),
        .o_year        (w_year),
        .o_month       (w_month),
        .o_day         (w_day)
    );

    // Result slot is free when empty or draining this cycle
    assign w_out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_year  <= w_year;
            r_out_month <= w_month;
            r_out_day   <= w_day;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_year  = r_out_year;
    assign o_res.out_month = r_out_month;
    assign o_res.out_day   = r_out_day;

endmodule

`default_nettype wire
